FILE: hdl/bit_quad_shape_features_core_macros.svh
// assertion macros for the bit quad shape features block
`ifndef BIT_QUAD_SHAPE_FEATURES_CORE_MACROS_SVH
`define BIT_QUAD_SHAPE_FEATURES_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define BQSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BQSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bqsf_pkg.sv
// ----------------------------------------------------------------------------
// bqsf_pkg
// shared constants and types of the bit quad shape features block
// ----------------------------------------------------------------------------
`default_nettype none

package bqsf_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  // register field widths
  localparam int BW_W = 10;
  localparam int BH_W = 9;

  localparam int PIX_W  = 8;
  localparam int CNT_W  = 18;
  localparam int PERI_W = 19;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [PIX_W-1:0] BACKGROUND = 8'hFF;

  localparam logic [BW_W-1:0] BOX_WIDTH_RST  = 10'd512;
  localparam logic [BH_W-1:0] BOX_HEIGHT_RST = 9'd256;

  typedef enum logic {
    REG_BOX_WIDTH  = 1'b0,
    REG_BOX_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    cnt_t one;
    cnt_t two;
    cnt_t three;
    cnt_t four;
    cnt_t diag;
  } quad_cnt_t;

endpackage

`default_nettype wire

FILE: hdl/bqsf_ram.sv
// ----------------------------------------------------------------------------
// bqsf_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bqsf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/bit_quad_shape_features_core.sv
// ----------------------------------------------------------------------------
// bit_quad_shape_features_core
// counts 2x2 bit quads over a box of pixels and reports euler number,
// area, perimeter and the quad counts after the last pixel of the box
// ----------------------------------------------------------------------------
//  channel   direction  handshake          beat
//  in_       input      in_valid/in_stall  one pixel byte, raster order
//  out_      output     out_valid/out_stall one result per box
//  config    apb        psel/penable       box_width (0x0), box_height (0x4)
//
//  one pixel per cycle unless stalled; line buffer ram read one beat ahead of use
//  result passes the count snapshot register, then the formula output register
//  in_stall rises only when the snapshot and the output register are both full
//  reset is synchronous; the line buffer needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module bit_quad_shape_features_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire logic [bqsf_pkg::PIX_W-1:0]           in_pixel,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic signed [bqsf_pkg::CNT_W-1:0]    out_euler_number,
  output      logic [bqsf_pkg::CNT_W-1:0]           out_area,
  output      logic [bqsf_pkg::PERI_W-1:0]          out_perimeter,
  output      logic [bqsf_pkg::CNT_W-1:0]           out_count_one,
  output      logic [bqsf_pkg::CNT_W-1:0]           out_count_two,
  output      logic [bqsf_pkg::CNT_W-1:0]           out_count_three,
  output      logic [bqsf_pkg::CNT_W-1:0]           out_count_four,
  output      logic [bqsf_pkg::CNT_W-1:0]           out_count_diagonal,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [bqsf_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [bqsf_pkg::DATA_W-1:0]          pwdata,
  output      logic [bqsf_pkg::DATA_W-1:0]          prdata,
  output      logic                                 pready
);

  localparam int COL_W = bqsf_pkg::COL_W;
  localparam int ROW_W = bqsf_pkg::ROW_W;
  localparam int BW_W  = bqsf_pkg::BW_W;
  localparam int BH_W  = bqsf_pkg::BH_W;
  localparam int CNT_W = bqsf_pkg::CNT_W;
  localparam int SUM_W = CNT_W + 4;

  // configuration
  logic [BW_W-1:0] box_width_r;
  logic [BH_W-1:0] box_height_r;
  logic            cfg_wr;
  bqsf_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = bqsf_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_width_r  <= bqsf_pkg::BOX_WIDTH_RST;
      box_height_r <= bqsf_pkg::BOX_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bqsf_pkg::REG_BOX_WIDTH:  box_width_r  <= pwdata[BW_W-1:0];
        bqsf_pkg::REG_BOX_HEIGHT: box_height_r <= pwdata[BH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bqsf_pkg::REG_BOX_WIDTH:  prdata = bqsf_pkg::DATA_W'(box_width_r);
      bqsf_pkg::REG_BOX_HEIGHT: prdata = bqsf_pkg::DATA_W'(box_height_r);
      default:                  prdata = '0;
    endcase
  end

  // clamped box size
  logic [BW_W-1:0] w_eff;
  logic [BH_W-1:0] h_eff;

  always_comb begin
    priority if (box_width_r < BW_W'(2)) begin
      w_eff = BW_W'(2);
    end else if (box_width_r > BW_W'(bqsf_pkg::MAX_WIDTH)) begin
      w_eff = BW_W'(bqsf_pkg::MAX_WIDTH);
    end else begin
      w_eff = box_width_r;
    end
    priority if (box_height_r < BH_W'(2)) begin
      h_eff = BH_W'(2);
    end else if (box_height_r > BH_W'(bqsf_pkg::MAX_HEIGHT)) begin
      h_eff = BH_W'(bqsf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = box_height_r;
    end
  end

  // pixel scan state
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             left_r, left_nxt;
  logic             upleft_r, upleft_nxt;
  bqsf_pkg::quad_cnt_t cnt_r, cnt_nxt, cnt_inc;

  logic in_acc;
  logic pix;
  logic up;
  logic last_col;
  logic last_row;
  logic box_done;

  assign in_acc   = in_valid && !in_stall;
  assign pix      = (in_pixel != bqsf_pkg::BACKGROUND);
  assign last_col = (BW_W'(col_r) + BW_W'(1)) >= w_eff;
  assign last_row = (BH_W'(row_r) + BH_W'(1)) >= h_eff;
  assign box_done = in_acc && last_col && last_row;

  // previous row, read one beat ahead at the next column
  bqsf_ram #(
    .WIDTH (1),
    .DEPTH (bqsf_pkg::MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col_r),
    .wdata (pix),
    .re    (in_acc),
    .raddr (col_nxt),
    .rdata (up)
  );

  // quad classification
  logic [2:0] qsum;

  always_comb begin
    cnt_inc = cnt_r;
    qsum    = 3'(upleft_r) + 3'(up) + 3'(left_r) + 3'(pix);
    if (row_r != '0 && col_r != '0) begin
      unique case (qsum)
        3'd1: cnt_inc.one = cnt_r.one + CNT_W'(1);
        3'd2: begin
          if (upleft_r == pix) begin
            cnt_inc.diag = cnt_r.diag + CNT_W'(1);
          end else begin
            cnt_inc.two = cnt_r.two + CNT_W'(1);
          end
        end
        3'd3: cnt_inc.three = cnt_r.three + CNT_W'(1);
        3'd4: cnt_inc.four  = cnt_r.four + CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    left_nxt   = left_r;
    upleft_nxt = upleft_r;
    cnt_nxt    = cnt_r;
    if (cfg_wr) begin
      col_nxt    = '0;
      row_nxt    = '0;
      left_nxt   = 1'b0;
      upleft_nxt = 1'b0;
      cnt_nxt    = '0;
    end else if (in_acc) begin
      cnt_nxt = cnt_inc;
      if (last_col) begin
        col_nxt    = '0;
        left_nxt   = 1'b0;
        upleft_nxt = 1'b0;
        if (last_row) begin
          row_nxt = '0;
          cnt_nxt = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt    = col_r + COL_W'(1);
        left_nxt   = pix;
        upleft_nxt = up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      left_r   <= 1'b0;
      upleft_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      left_r   <= left_nxt;
      upleft_r <= upleft_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // count snapshot and result register
  logic                snap_valid_r, snap_valid_nxt;
  bqsf_pkg::quad_cnt_t snap_r;
  logic                out_valid_r, out_valid_nxt;
  logic                snap_move;

  assign in_stall  = snap_valid_r && out_valid_r && out_stall;
  assign snap_move = snap_valid_r && (!out_valid_r || !out_stall);

  always_comb begin
    snap_valid_nxt = box_done || (snap_valid_r && !snap_move);
    out_valid_nxt  = snap_move || (out_valid_r && out_stall);
  end

  logic signed [SUM_W-1:0] euler_sum;
  logic signed [SUM_W-1:0] euler_adj;
  logic        [SUM_W-1:0] area_sum;
  logic        [SUM_W-1:0] peri_sum;

  always_comb begin
    euler_sum = $signed(SUM_W'(snap_r.one)) - $signed(SUM_W'(snap_r.three))
              + $signed(SUM_W'(snap_r.diag) << 1);
    euler_adj = (euler_sum < 0) ? (euler_sum + SUM_W'(3)) : euler_sum;
    area_sum  = SUM_W'(snap_r.one) + (SUM_W'(snap_r.two) << 1)
              + SUM_W'(snap_r.three) + (SUM_W'(snap_r.three) << 1)
              + (SUM_W'(snap_r.four) << 2) + (SUM_W'(snap_r.diag) << 1);
    peri_sum  = SUM_W'(snap_r.one) + SUM_W'(snap_r.two) + SUM_W'(snap_r.three)
              + (SUM_W'(snap_r.diag) << 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (box_done) begin
      snap_r <= cnt_inc;
    end
    if (snap_move) begin
      out_euler_number   <= CNT_W'(euler_adj >>> 2);
      out_area           <= area_sum[CNT_W+1:2];
      out_perimeter      <= peri_sum[bqsf_pkg::PERI_W-1:0];
      out_count_one      <= snap_r.one;
      out_count_two      <= snap_r.two;
      out_count_three    <= snap_r.three;
      out_count_four     <= snap_r.four;
      out_count_diagonal <= snap_r.diag;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: hdl/bqsf_chk.sv
// ----------------------------------------------------------------------------
// bqsf_chk
// port-level checks of the bit quad shape features block
// ----------------------------------------------------------------------------
`default_nettype none

`include "bit_quad_shape_features_core_macros.svh"

module bqsf_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [bqsf_pkg::CNT_W-1:0] out_euler_number,
  input wire logic [bqsf_pkg::CNT_W-1:0]        out_area,
  input wire logic [bqsf_pkg::PERI_W-1:0]       out_perimeter,
  input wire logic [bqsf_pkg::CNT_W-1:0]        out_count_one,
  input wire logic [bqsf_pkg::CNT_W-1:0]        out_count_two,
  input wire logic [bqsf_pkg::CNT_W-1:0]        out_count_three,
  input wire logic [bqsf_pkg::CNT_W-1:0]        out_count_four,
  input wire logic [bqsf_pkg::CNT_W-1:0]        out_count_diagonal
);

  localparam int SUM_W = bqsf_pkg::CNT_W + 4;

  logic [SUM_W-1:0] peri_chk;
  logic [SUM_W-1:0] area_chk;

  assign peri_chk = SUM_W'(out_count_one) + SUM_W'(out_count_two)
                  + SUM_W'(out_count_three) + (SUM_W'(out_count_diagonal) << 1);
  assign area_chk = SUM_W'(out_count_one) + (SUM_W'(out_count_two) << 1)
                  + SUM_W'(out_count_three) + (SUM_W'(out_count_three) << 1)
                  + (SUM_W'(out_count_four) << 2) + (SUM_W'(out_count_diagonal) << 1);

  `BQSF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
    "result beat dropped while stalled")

  `BQSF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall,
    $stable(out_euler_number) && $stable(out_perimeter),
    "stalled result beat changed")

  `BQSF_ASSERT_NOW(a_peri, clk, rst_n, out_valid,
    out_perimeter == peri_chk[bqsf_pkg::PERI_W-1:0],
    "perimeter disagrees with quad counts")

  `BQSF_ASSERT_NOW(a_area, clk, rst_n, out_valid,
    out_area == area_chk[bqsf_pkg::CNT_W+1:2],
    "area disagrees with quad counts")

endmodule

bind bit_quad_shape_features_core bqsf_chk u_bqsf_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_euler_number   (out_euler_number),
  .out_area           (out_area),
  .out_perimeter      (out_perimeter),
  .out_count_one      (out_count_one),
  .out_count_two      (out_count_two),
  .out_count_three    (out_count_three),
  .out_count_four     (out_count_four),
  .out_count_diagonal (out_count_diagonal)
);

`default_nettype wire

FILE: tb/bit_quad_shape_features_core_tb.sv
// ----------------------------------------------------------------------------
// bit_quad_shape_features_core_tb
// self-checking bench for the bit quad shape features block: a queue-fed
// driver streams pixel boxes, a behavioral quad counter predicts the euler
// number, area, perimeter and quad counts of each box, and a monitor checks
// every result beat field by field while both sides idle and stall at random
// ----------------------------------------------------------------------------
module bit_quad_shape_features_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bqsf_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_PIXELS = 580;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int IDLE_PCT      = 32;

  typedef struct packed {
    logic signed [CNT_W-1:0] euler;
    cnt_t                    area;
    logic [PERI_W-1:0]       perimeter;
    quad_cnt_t               quads;
  } shape_result_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic [PIX_W-1:0]        in_pixel  = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [CNT_W-1:0] out_euler_number;
  logic [CNT_W-1:0]        out_area;
  logic [PERI_W-1:0]       out_perimeter;
  logic [CNT_W-1:0]        out_count_one;
  logic [CNT_W-1:0]        out_count_two;
  logic [CNT_W-1:0]        out_count_three;
  logic [CNT_W-1:0]        out_count_four;
  logic [CNT_W-1:0]        out_count_diagonal;
  logic                    psel      = 1'b0;
  logic                    penable   = 1'b0;
  logic                    pwrite    = 1'b0;
  logic [ADDR_W-1:0]       paddr     = '0;
  logic [DATA_W-1:0]       pwdata    = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  // quad counter state
  bit               line_mem [MAX_WIDTH];
  int unsigned      col_pos;
  int unsigned      row_pos;
  bit               left_fg;
  bit               upleft_fg;
  quad_cnt_t        quads;
  logic [BW_W-1:0]  width_reg  = BOX_WIDTH_RST;
  logic [BH_W-1:0]  height_reg = BOX_HEIGHT_RST;

  logic [PIX_W-1:0] pixel_q [$];
  shape_result_t    expected_features [$];
  shape_result_t    want_feat;

  bit quiet_run    = 1'b0;
  int err_count    = 0;
  int pixels_taken = 0;
  int results_seen = 0;
  int writes_done  = 0;
  int cut_boxes    = 0;
  int quiet_cycles = 0;

  bit_quad_shape_features_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pixel           (in_pixel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_euler_number   (out_euler_number),
    .out_area           (out_area),
    .out_perimeter      (out_perimeter),
    .out_count_one      (out_count_one),
    .out_count_two      (out_count_two),
    .out_count_three    (out_count_three),
    .out_count_four     (out_count_four),
    .out_count_diagonal (out_count_diagonal),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_box();
    col_pos   = 0;
    row_pos   = 0;
    left_fg   = 1'b0;
    upleft_fg = 1'b0;
    quads     = '0;
  endfunction

  function automatic void accumulate_quad(logic [PIX_W-1:0] px);
    int unsigned   w;
    int unsigned   h;
    int unsigned   sum;
    bit            fg;
    bit            up;
    int            q1;
    int            q2;
    int            q3;
    int            q4;
    int            qd;
    shape_result_t res;
    w  = clamp_size(width_reg, MAX_WIDTH);
    h  = clamp_size(height_reg, MAX_HEIGHT);
    fg = (px != BACKGROUND);
    up = line_mem[col_pos];
    if (row_pos >= 1 && col_pos >= 1) begin
      sum = int'(upleft_fg) + int'(up) + int'(left_fg) + int'(fg);
      case (sum)
        1: quads.one = quads.one + 1'b1;
        2: begin
          // equal corners on one diagonal means the other diagonal matches too
          if (upleft_fg == fg) quads.diag = quads.diag + 1'b1;
          else quads.two = quads.two + 1'b1;
        end
        3: quads.three = quads.three + 1'b1;
        4: quads.four = quads.four + 1'b1;
        default: ;
      endcase
    end
    line_mem[col_pos] = fg;
    left_fg   = fg;
    upleft_fg = up;
    if (col_pos + 1 >= w) begin
      col_pos   = 0;
      left_fg   = 1'b0;
      upleft_fg = 1'b0;
      if (row_pos + 1 >= h) begin
        q1 = int'(quads.one);
        q2 = int'(quads.two);
        q3 = int'(quads.three);
        q4 = int'(quads.four);
        qd = int'(quads.diag);
        res.euler     = CNT_W'((q1 - q3 + 2 * qd) / 4);
        res.area      = CNT_W'((q1 + 2 * q2 + 3 * q3 + 4 * q4 + 2 * qd) / 4);
        res.perimeter = PERI_W'(q1 + q2 + q3 + 2 * qd);
        res.quads     = quads;
        expected_features.push_back(res);
        restart_box();
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        accumulate_quad(in_pixel);
        pixels_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() != 0 && (quiet_run || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_pixel <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_pixel <= PIX_W'($urandom);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_features.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want_feat = expected_features.pop_front();
          check_field("euler_number", out_euler_number, want_feat.euler);
          check_field("area", out_area, want_feat.area);
          check_field("perimeter", out_perimeter, want_feat.perimeter);
          check_field("count_one", out_count_one, want_feat.quads.one);
          check_field("count_two", out_count_two, want_feat.quads.two);
          check_field("count_three", out_count_three, want_feat.quads.three);
          check_field("count_four", out_count_four, want_feat.quads.four);
          check_field("count_diagonal", out_count_diagonal, want_feat.quads.diag);
        end
      end
      out_stall <= !quiet_run && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_features.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_access(input reg_idx_t idx, input bit is_write,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input reg_idx_t idx);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] want;
    want = (idx == REG_BOX_WIDTH) ? DATA_W'(width_reg) : DATA_W'(height_reg);
    apb_access(idx, 1'b0, '0, rd);
    if (rd !== want) begin
      report_mismatch($sformatf("%s read %0d expected %0d", idx.name(), rd, want));
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned field);
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rd;
    // bits above the field are don't-care on write
    wdata = $urandom_range(1) ? DATA_W'($urandom) : '0;
    if (idx == REG_BOX_WIDTH) wdata[BW_W-1:0] = BW_W'(field);
    else wdata[BH_W-1:0] = BH_W'(field);
    apb_access(idx, 1'b1, wdata, rd);
    if (idx == REG_BOX_WIDTH) width_reg = wdata[BW_W-1:0];
    else height_reg = wdata[BH_W-1:0];
    restart_box();
    writes_done++;
    check_reg(idx);
  endtask

  task automatic settle();
    @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || expected_features.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int unsigned pick_size(int unsigned common_hi, int unsigned rare_hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return $urandom_range(1, 0);
    if (r < 15) return $urandom_range(rare_hi, common_hi + 1);
    return $urandom_range(common_hi, 2);
  endfunction

  function automatic void queue_quad(logic [PIX_W-1:0] tl, logic [PIX_W-1:0] tr,
                                     logic [PIX_W-1:0] bl, logic [PIX_W-1:0] br);
    pixel_q.push_back(tl);
    pixel_q.push_back(tr);
    pixel_q.push_back(bl);
    pixel_q.push_back(br);
  endfunction

  function automatic void queue_box(int unsigned w, int unsigned h, int unsigned n);
    int unsigned style;
    int unsigned density;
    int unsigned x0;
    int unsigned x1;
    int unsigned y0;
    int unsigned y1;
    int unsigned x;
    int unsigned y;
    bit          fg;
    style   = $urandom_range(3);
    density = $urandom_range(100);
    x0      = $urandom_range(w - 1);
    x1      = $urandom_range(w - 1, x0);
    y0      = $urandom_range(h - 1);
    y1      = $urandom_range(h - 1, y0);
    for (int unsigned i = 0; i < n; i++) begin
      x = i % w;
      y = i / w;
      case (style)
        0: fg = ($urandom_range(99) < density);
        1: fg = ((x + y) % 2 == 0) ^ ($urandom_range(99) < 5);
        2: fg = (x >= x0 && x <= x1 && y >= y0 && y <= y1) ^ ($urandom_range(99) < 8);
        default: fg = (density >= 50);
      endcase
      pixel_q.push_back(fg ? PIX_W'($urandom_range(254)) : BACKGROUND);
    end
  endfunction

  initial begin
    int unsigned ext_w [2];
    int unsigned ext_h [2];
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned pick;
    int          phase_no;
    int          random_pixels;
    ext_w = '{1, 0};
    ext_h = '{0, 1};
    restart_box();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_reg(REG_BOX_WIDTH);
    check_reg(REG_BOX_HEIGHT);

    // start a box at the reset size, then restart it by a write
    @(negedge clk);
    queue_box(MAX_WIDTH, MAX_HEIGHT, 37);
    cut_boxes++;
    settle();

    write_reg(REG_BOX_WIDTH, 2);
    write_reg(REG_BOX_HEIGHT, 2);
    @(negedge clk);
    queue_quad(8'd255, 8'd255, 8'd255, 8'd255);
    queue_quad(8'd0, 8'd254, 8'd1, 8'd128);
    queue_quad(8'd0, 8'd255, 8'd255, 8'd254);
    queue_quad(8'd255, 8'd127, 8'd128, 8'd255);
    queue_quad(8'd255, 8'd255, 8'd255, 8'd1);
    queue_quad(8'd2, 8'd4, 8'd8, 8'd255);
    queue_quad(8'd16, 8'd32, 8'd255, 8'd255);
    settle();

    // sizes below the minimum, which clamp
    for (int i = 0; i < 2; i++) begin
      write_reg(REG_BOX_WIDTH, ext_w[i]);
      write_reg(REG_BOX_HEIGHT, ext_h[i]);
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, MAX_HEIGHT);
      @(negedge clk);
      queue_box(w, h, w * h);
      settle();
    end

    phase_no      = 0;
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      quiet_run = (phase_no >= 2 && phase_no < 6);
      pick = $urandom_range(2);
      if (pick != 1) write_reg(REG_BOX_WIDTH, pick_size(8, 24));
      if (pick != 0) write_reg(REG_BOX_HEIGHT, pick_size(6, 16));
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, MAX_HEIGHT);
      @(negedge clk);
      repeat ($urandom_range(4, 1)) begin
        queue_box(w, h, w * h);
        random_pixels += w * h;
      end
      if ($urandom_range(99) < 15) begin
        n = $urandom_range(w * h - 1, 1);
        queue_box(w, h, n);
        random_pixels += n;
        cut_boxes++;
      end
      settle();
      phase_no++;
    end

    quiet_run = 1'b0;
    settle();
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    $display("run: %0d pixels, %0d result beats, %0d register writes, %0d boxes cut short",
             pixels_taken, results_seen, writes_done, cut_boxes);
    $display("sizes from 2x2 to 24x16 with clamped low values, %0d random phases",
             phase_no);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/bqsf_pkg.sv
hdl/bqsf_ram.sv
hdl/bit_quad_shape_features_core.sv
hdl/bqsf_chk.sv
tb/bit_quad_shape_features_core_tb.sv
